[rtl/ukf_pkg.sv]
// shared types, codes and defaults for the unique-key fifo
package ukf_pkg;

    localparam int UKF_DEPTH = 16;

    localparam logic [1:0] ACT_ENQ   = 2'd0;
    localparam logic [1:0] ACT_DEQ   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_RSVD  = 2'd3;

    typedef enum logic [2:0] {
        ST_ENQUEUED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_DEQUEUED  = 3'd3,
        ST_UNDERFLOW = 3'd4,
        ST_QUERY     = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] new_key;
        logic signed [31:0] new_value;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_key;
        logic signed [31:0] out_value;
        logic [4:0]         entry_count;
        logic               empty_flag;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DEQ_RD,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic deq_rd;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic hit;
    } t_dp_stat;

endpackage

[rtl/ukf_ram.sv]
// generic single-write, single-read ram with registered read data
module ukf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ukf_datapath.sv]
// ring pointers, fill count, key scan and result register
module ukf_datapath import ukf_pkg::*; #(
    parameter int DEPTH = UKF_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_cmd  i_cmd,
    input  t_in      i_item,
    output t_dp_stat o_stat,
    output t_out     o_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_left, n_left;
    logic          r_pend, n_pend;
    logic          r_hit, n_hit;
    t_in           r_item, n_item;
    t_out          r_out, n_out;

    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [63:0]   ram_rdata;
    logic signed [31:0] rd_key;
    logic signed [31:0] rd_value;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
    endfunction

    assign rd_key   = ram_rdata[63:32];
    assign rd_value = ram_rdata[31:0];

    // scan reads walk from head, dequeue reads the head slot
    assign ram_re    = (i_cmd.scan && (r_left != '0)) || i_cmd.deq_rd;
    assign ram_raddr = i_cmd.deq_rd ? r_head : r_ptr;

    ukf_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata ({r_item.new_key, r_item.new_value}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_ptr   = r_ptr;
        n_left  = r_left;
        n_pend  = r_pend;
        n_hit   = r_hit;
        n_item  = r_item;
        n_out   = r_out;
        ram_we  = 1'b0;

        if (i_cmd.load) begin
            n_item = i_item;
            n_ptr  = r_head;
            n_left = r_count;
            n_pend = 1'b0;
            n_hit  = 1'b0;
        end

        if (i_cmd.scan) begin
            n_pend = (r_left != '0);
            if (r_left != '0) begin
                n_ptr  = next_slot(r_ptr);
                n_left = r_left - CW'(1);
            end
            if (r_pend && (rd_key == r_item.new_key)) begin
                n_hit = 1'b1;
            end
        end

        if (i_cmd.commit) begin
            n_out.status    = ST_QUERY;
            n_out.out_key   = '0;
            n_out.out_value = '0;
            unique case (r_item.action)
                ACT_ENQ: begin
                    if (r_hit) begin
                        n_out.status = ST_DUPLICATE;
                    end else if (r_count == CW'(DEPTH)) begin
                        n_out.status = ST_FULL;
                    end else begin
                        ram_we       = 1'b1;
                        n_tail       = next_slot(r_tail);
                        n_count      = r_count + CW'(1);
                        n_out.status = ST_ENQUEUED;
                    end
                end
                ACT_DEQ: begin
                    if (r_count == '0) begin
                        n_out.status = ST_UNDERFLOW;
                    end else begin
                        n_out.out_key   = rd_key;
                        n_out.out_value = rd_value;
                        n_head          = next_slot(r_head);
                        n_count         = r_count - CW'(1);
                        n_out.status    = ST_DEQUEUED;
                    end
                end
                default: begin
                    n_out.status = ST_QUERY;
                end
            endcase
            n_out.entry_count = 5'(n_count);
            n_out.empty_flag  = (n_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_hit   <= 1'b0;
            r_left  <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_hit   <= n_hit;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_item <= n_item;
        r_out  <= n_out;
    end

    assign o_stat.scan_done = (r_left == '0) && !r_pend;
    assign o_stat.hit       = r_hit;
    assign o_item           = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_ring_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CW'(DEPTH)) |-> (r_head == r_tail))
        else $error("head and tail disagree with empty or full ring");

endmodule

[rtl/ukf_ctrl.sv]
// sequencer for load, key scan, dequeue read and result commit
module ukf_ctrl import ukf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_action,
    input  logic       i_out_stall,
    input  t_dp_stat   i_stat,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   out_free;

    // result register can take a new transaction this cycle
    assign out_free = !r_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_action)
                        ACT_ENQ: n_state = S_SCAN;
                        ACT_DEQ: n_state = S_DEQ_RD;
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done || i_stat.hit) begin
                    n_state = S_FIN;
                end
            end
            S_DEQ_RD: n_state = S_FIN;
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.deq_rd = (r_state == S_DEQ_RD);
        o_cmd.commit = (r_state == S_FIN) && out_free;
        o_in_stall   = (r_state != S_IDLE);
    end

    always_comb begin
        priority if (o_cmd.commit) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_out_valid = r_valid;

    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state != S_IDLE))
        else $error("accepted transaction left no work in flight");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("committed result not presented");

endmodule

[rtl/unique_key_fifo.sv]
// top level of the fifo of key/value pairs that refuses duplicate keys
// enqueue: the key scan reads the filled slots from the head, one slot a cycle;
// a duplicate key ends the scan early
// dequeue: one registered ram read of the head slot; query: no ram read
// next transaction is accepted in the cycle after the result is registered
// reset: synchronous active low, empties the ring; slot contents are left as they were
module unique_key_fifo import ukf_pkg::*; #(
    parameter int DEPTH = UKF_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ukf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_action (i_in_data.action),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    ukf_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_item  (i_in_data),
        .o_stat  (stat),
        .o_item  (o_out_data)
    );

endmodule

[sim/tb_unique_key_fifo.sv]
// testbench for the unique-key fifo: directed and random enqueue/dequeue/query traffic checked against a ring model
`timescale 1ns / 100ps

module tb_unique_key_fifo;
    import ukf_pkg::*;

    localparam int RANDOM_OPS   = 650;
    localparam int BURST_LEN    = 40;
    localparam int IDLE_PCT     = 35;
    localparam int CALM_FIRST   = 300;
    localparam int CALM_LAST    = 400;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 40;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;

    unique_key_fifo u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    t_in         ops_to_send[$];
    t_out        expected_status_q[$];
    int          total_ops;
    int          sent_cnt;
    int          got_cnt;
    int          errors;
    logic        in_fire;
    int          hold_left;
    int          hold_mark;
    logic [31:0] key_pool[24];

    // ring copy of the queue contents
    logic [31:0] ring_key[UKF_DEPTH];
    logic [31:0] ring_val[UKF_DEPTH];
    int unsigned ring_head;
    int unsigned ring_tail;
    int unsigned ring_fill;

    function automatic t_out next_fifo_status(t_in txn);
        t_out        res;
        logic        hit;
        int unsigned idx;
        res = '0;
        case (txn.action)
            ACT_ENQ: begin
                hit = 1'b0;
                idx = ring_head;
                for (int i = 0; i < ring_fill; i++) begin
                    if (ring_key[idx] == txn.new_key)
                        hit = 1'b1;
                    idx = (idx + 1) % UKF_DEPTH;
                end
                // duplicate check wins over the full check
                if (hit) begin
                    res.status = ST_DUPLICATE;
                end else if (ring_fill >= UKF_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    ring_key[ring_tail] = txn.new_key;
                    ring_val[ring_tail] = txn.new_value;
                    ring_tail = (ring_tail + 1) % UKF_DEPTH;
                    ring_fill++;
                    res.status = ST_ENQUEUED;
                end
            end
            ACT_DEQ: begin
                if (ring_fill == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    res.out_key   = ring_key[ring_head];
                    res.out_value = ring_val[ring_head];
                    ring_head = (ring_head + 1) % UKF_DEPTH;
                    ring_fill--;
                    res.status = ST_DEQUEUED;
                end
            end
            // the unused action code is treated as a query
            default: res.status = ST_QUERY;
        endcase
        res.entry_count = ring_fill[4:0];
        res.empty_flag  = (ring_fill == 0);
        return res;
    endfunction

    task automatic add_op(logic [1:0] act, logic [31:0] key, logic [31:0] val);
        t_in txn;
        txn.action    = act;
        txn.new_key   = key;
        txn.new_value = val;
        ops_to_send.push_back(txn);
    endtask

    function automatic logic [31:0] pick_key();
        if ($urandom_range(99) < 75)
            return key_pool[$urandom_range(23)];
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, fname, want, got);
        end
    endtask

    // input acceptance feeds the model, output acceptance is checked
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= i_in_valid && !o_in_stall;
            if (o_out_valid && !i_out_stall) begin
                got_cnt++;
                if (expected_status_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transaction, expected none actual %h",
                             $time, o_out_data);
                end else begin
                    want = expected_status_q.pop_front();
                    check_field("status", 32'(want.status), 32'(o_out_data.status));
                    check_field("out_key", want.out_key, o_out_data.out_key);
                    check_field("out_value", want.out_value, o_out_data.out_value);
                    check_field("entry_count", 32'(want.entry_count),
                                32'(o_out_data.entry_count));
                    check_field("empty_flag", 32'(want.empty_flag),
                                32'(o_out_data.empty_flag));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                sent_cnt++;
                expected_status_q.push_back(next_fifo_status(i_in_data));
            end
        end
    end

    // sender: a new transaction is offered only once the held one is taken
    always @(negedge i_clk) begin
        logic calm;
        calm = (sent_cnt >= CALM_FIRST) && (sent_cnt < CALM_LAST);
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (ops_to_send.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                i_in_data  <= ops_to_send.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus long hold-offs that back up the input side
    always @(negedge i_clk) begin
        logic calm;
        calm = (got_cnt >= CALM_FIRST) && (got_cnt < CALM_LAST);
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (i_rst_n && got_cnt >= hold_mark) begin
            hold_left   <= HOLD_CYCLES;
            hold_mark   <= hold_mark + 330;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial begin
        int enq_pct;
        int r;
        logic [1:0] act;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        sent_cnt    = 0;
        got_cnt     = 0;
        errors      = 0;
        hold_left   = 0;
        hold_mark   = 120;
        ring_head   = 0;
        ring_tail   = 0;
        ring_fill   = 0;

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 24; i++)
            key_pool[i] = $urandom;

        // empty queue cases
        add_op(ACT_QUERY, 32'h0000_0000, 32'h0000_0000);
        add_op(ACT_DEQ, 32'hffff_ffff, 32'hffff_ffff);
        add_op(ACT_RSVD, 32'h1234_5678, 32'h9abc_def0);
        // extreme keys, then a repeat of one
        add_op(ACT_ENQ, 32'h8000_0000, 32'h7fff_ffff);
        add_op(ACT_ENQ, 32'h8000_0000, 32'h0000_0001);
        add_op(ACT_ENQ, 32'h7fff_ffff, 32'h8000_0000);
        // fill the ring, then a fresh key and a repeated key while full
        for (int i = 0; i < UKF_DEPTH - 2; i++)
            add_op(ACT_ENQ, 32'h0000_1000 + i, $urandom);
        add_op(ACT_ENQ, 32'hffff_ffff, 32'hffff_ffff);
        add_op(ACT_ENQ, 32'h7fff_ffff, 32'h0000_0000);
        add_op(ACT_DEQ, 32'h0000_0000, 32'h0000_0000);

        // bursts with a random enqueue bias so the ring swings between empty and full
        enq_pct = 50;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % BURST_LEN == 0)
                enq_pct = $urandom_range(85, 15);
            r = $urandom_range(99);
            if (r < enq_pct) begin
                act = ACT_ENQ;
            end else begin
                case ($urandom_range(9))
                    0: act = ACT_QUERY;
                    1: act = ACT_RSVD;
                    default: act = ACT_DEQ;
                endcase
            end
            add_op(act, pick_key(), pick_value());
        end
        total_ops = ops_to_send.size();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_cnt < total_ops)
            @(posedge i_clk);
        while (expected_status_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/ukf_pkg.sv
rtl/ukf_ram.sv
rtl/ukf_datapath.sv
rtl/ukf_ctrl.sv
rtl/unique_key_fifo.sv
sim/tb_unique_key_fifo.sv
